@@ hw/rtl/sci_pkg.sv @@
// ----------------------------------------------------------------------------
// sci_pkg - shared constants for the segment / circle intersection block
// Radius register format and default parameter values.
// ----------------------------------------------------------------------------
package sci_pkg;

  // lookahead radius register, unsigned, 1/16 mm
  localparam int unsigned RADIUS_W = 19;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 19'd4877;

  // default geometry
  localparam int unsigned COORD_WIDTH_DEF = 20;
  localparam int unsigned T_FRAC_BITS_DEF = 16;

  // number of fixed front-end stages ahead of the root chain
  localparam int unsigned FRONT_STAGES = 6;

endpackage

@@ hw/rtl/sci_front.sv @@
// ----------------------------------------------------------------------------
// sci_front - quadratic coefficient front end
// Forms a = d.d, g = f.d and the quarter discriminant r*r*a - (f x d)^2,
// six registered stages with split partial products on the wide squares.
// ----------------------------------------------------------------------------
module sci_front #(
  parameter int unsigned COORD_WIDTH = sci_pkg::COORD_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic [sci_pkg::FRONT_STAGES-1:0]                en,
  input  logic                                            in_valid,
  input  logic [6*COORD_WIDTH-1:0]                        in_data,
  input  logic [sci_pkg::RADIUS_W-1:0]                    radius,
  output logic [sci_pkg::FRONT_STAGES-1:0]                valid_o,
  output logic                                            ok_o,
  output logic [2*COORD_WIDTH+2+2*sci_pkg::RADIUS_W+1:0]  disc_o,
  output logic signed [2*COORD_WIDTH+2:0]                 g_o,
  output logic [2*COORD_WIDTH+1:0]                        a_o
);

  localparam int unsigned DW  = COORD_WIDTH + 1;
  localparam int unsigned H   = COORD_WIDTH + 1;
  localparam int unsigned AW  = 2 * H;
  localparam int unsigned GW  = 2 * DW + 1;
  localparam int unsigned RH  = sci_pkg::RADIUS_W;
  localparam int unsigned RW2 = 2 * RH;
  localparam int unsigned PW  = (2 * AW > RW2 + AW) ? 2 * AW : RW2 + AW;
  localparam int unsigned VW  = AW + RW2 + 2;

  logic [sci_pkg::FRONT_STAGES-1:0] valid_r;

  // stage 1: differences
  logic signed [COORD_WIDTH-1:0] sx, sy, ex, ey, px, py;
  logic signed [DW-1:0] dx_nxt, dy_nxt, fx_nxt, fy_nxt;
  logic signed [DW-1:0] dx_r, dy_r, fx_r, fy_r;
  logic [RH-1:0]        r1_r;

  // stage 2: products
  logic signed [2*DW-1:0] p_dxx_r, p_dyy_r, p_fd1_r, p_fd2_r, p_c1_r, p_c2_r;
  logic [RW2-1:0]         r2_s2_r;

  // stage 3: coefficients
  logic [AW-1:0]        a_nxt, a_s3_r, crm_nxt, crm_r;
  logic signed [GW-1:0] g_nxt, g_s3_r, cr_nxt;
  logic [RW2-1:0]       r2_s3_r;

  // stage 4: partial products
  logic [2*H-1:0]       q_ll_r, q_lh_r, q_hh_r;
  logic [RH+H-1:0]      m_ll_r, m_lh_r, m_hl_r, m_hh_r;
  logic [AW-1:0]        a_s4_r;
  logic signed [GW-1:0] g_s4_r;
  logic                 azero_s4_r;

  // stage 5: full squares
  logic [PW-1:0]        cr2_nxt, cr2_r, r2a_nxt, r2a_r;
  logic [AW-1:0]        a_s5_r;
  logic signed [GW-1:0] g_s5_r;
  logic                 azero_s5_r;

  // stage 6: discriminant
  logic signed [PW:0]   x_nxt;
  logic                 ok_nxt, ok_r;
  logic [VW-1:0]        disc_nxt, disc_r;
  logic [AW-1:0]        a_s6_r;
  logic signed [GW-1:0] g_s6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < sci_pkg::FRONT_STAGES; k++) begin
        if (en[k]) begin
          valid_r[k] <= (k == 0) ? in_valid : valid_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign sx = $signed(in_data[0*COORD_WIDTH +: COORD_WIDTH]);
  assign sy = $signed(in_data[1*COORD_WIDTH +: COORD_WIDTH]);
  assign ex = $signed(in_data[2*COORD_WIDTH +: COORD_WIDTH]);
  assign ey = $signed(in_data[3*COORD_WIDTH +: COORD_WIDTH]);
  assign px = $signed(in_data[4*COORD_WIDTH +: COORD_WIDTH]);
  assign py = $signed(in_data[5*COORD_WIDTH +: COORD_WIDTH]);

  assign dx_nxt = DW'(ex) - DW'(sx);
  assign dy_nxt = DW'(ey) - DW'(sy);
  assign fx_nxt = DW'(sx) - DW'(px);
  assign fy_nxt = DW'(sy) - DW'(py);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      fx_r <= fx_nxt;
      fy_r <= fy_nxt;
      r1_r <= radius;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_dxx_r <= dx_r * dx_r;
      p_dyy_r <= dy_r * dy_r;
      p_fd1_r <= fx_r * dx_r;
      p_fd2_r <= fy_r * dy_r;
      p_c1_r  <= fx_r * dy_r;
      p_c2_r  <= fy_r * dx_r;
      r2_s2_r <= RW2'(r1_r) * RW2'(r1_r);
    end
  end

  // squares are non-negative, so the product bits read as unsigned
  assign a_nxt   = AW'(unsigned'(p_dxx_r)) + AW'(unsigned'(p_dyy_r));
  assign g_nxt   = GW'(p_fd1_r) + GW'(p_fd2_r);
  assign cr_nxt  = GW'(p_c1_r) - GW'(p_c2_r);
  assign crm_nxt = cr_nxt[GW-1] ? AW'(unsigned'(-cr_nxt)) : AW'(unsigned'(cr_nxt));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a_s3_r  <= a_nxt;
      g_s3_r  <= g_nxt;
      crm_r   <= crm_nxt;
      r2_s3_r <= r2_s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      q_ll_r     <= (2*H)'(crm_r[H-1:0]) * (2*H)'(crm_r[H-1:0]);
      q_lh_r     <= (2*H)'(crm_r[H-1:0]) * (2*H)'(crm_r[AW-1:H]);
      q_hh_r     <= (2*H)'(crm_r[AW-1:H]) * (2*H)'(crm_r[AW-1:H]);
      m_ll_r     <= (RH+H)'(r2_s3_r[RH-1:0]) * (RH+H)'(a_s3_r[H-1:0]);
      m_lh_r     <= (RH+H)'(r2_s3_r[RH-1:0]) * (RH+H)'(a_s3_r[AW-1:H]);
      m_hl_r     <= (RH+H)'(r2_s3_r[RW2-1:RH]) * (RH+H)'(a_s3_r[H-1:0]);
      m_hh_r     <= (RH+H)'(r2_s3_r[RW2-1:RH]) * (RH+H)'(a_s3_r[AW-1:H]);
      a_s4_r     <= a_s3_r;
      g_s4_r     <= g_s3_r;
      azero_s4_r <= (a_s3_r == '0);
    end
  end

  assign cr2_nxt = (PW'(q_hh_r) << (2*H)) + (PW'(q_lh_r) << (H+1)) + PW'(q_ll_r);
  assign r2a_nxt = (PW'(m_hh_r) << (RH+H)) + (PW'(m_hl_r) << RH)
                 + (PW'(m_lh_r) << H) + PW'(m_ll_r);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      cr2_r      <= cr2_nxt;
      r2a_r      <= r2a_nxt;
      a_s5_r     <= a_s4_r;
      g_s5_r     <= g_s4_r;
      azero_s5_r <= azero_s4_r;
    end
  end

  // quarter discriminant by the Lagrange identity: r^2 a - (f x d)^2
  assign x_nxt    = $signed({1'b0, r2a_r}) - $signed({1'b0, cr2_r});
  assign ok_nxt   = !azero_s5_r && !x_nxt[PW];
  assign disc_nxt = ok_nxt ? (VW'(x_nxt[PW-1:0]) << 2) : '0;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      ok_r   <= ok_nxt;
      disc_r <= disc_nxt;
      a_s6_r <= a_s5_r;
      g_s6_r <= g_s5_r;
    end
  end

  assign valid_o = valid_r;
  assign ok_o    = ok_r;
  assign disc_o  = disc_r;
  assign g_o     = g_s6_r;
  assign a_o     = a_s6_r;

endmodule

@@ hw/rtl/sci_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// sci_sqrt_cell - one root bit of the floor square root chain
// Takes two radicand bits, tries (root<<2)|1 against the partial remainder.
// ----------------------------------------------------------------------------
module sci_sqrt_cell #(
  parameter int unsigned RB = 41,
  parameter int unsigned SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_i,
  input  logic [RB+1:0]   rem_i,
  input  logic [RB-1:0]   root_i,
  input  logic [2*RB-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RB+1:0]   rem_o,
  output logic [RB-1:0]   root_o,
  output logic [2*RB-1:0] rad_o,
  output logic [SW-1:0]   side_o
);

  logic [RB+3:0] rem_t, trial;
  logic          ge;
  logic          valid_r;
  logic [RB+1:0] rem_r;
  logic [RB-1:0] root_r;
  logic [2*RB-1:0] rad_r;
  logic [SW-1:0] side_r;

  assign rem_t = {rem_i, rad_i[2*RB-1:2*RB-2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign ge    = (rem_t >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? (RB+2)'(rem_t - trial) : (RB+2)'(rem_t);
      root_r <= {root_i[RB-2:0], ge};
      rad_r  <= {rad_i[2*RB-3:0], 2'b00};
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign rad_o   = rad_r;
  assign side_o  = side_r;

endmodule

@@ hw/rtl/sci_div_cell.sv @@
// ----------------------------------------------------------------------------
// sci_div_cell - one quotient bit of the restoring divider chain
// Compares the running remainder with the divisor, subtracts, shifts left.
// ----------------------------------------------------------------------------
module sci_div_cell #(
  parameter int unsigned DNW = 43,
  parameter int unsigned QW  = 17,
  parameter int unsigned SW  = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_i,
  input  logic [DNW:0]   rem_i,
  input  logic [DNW-1:0] den_i,
  input  logic [QW-1:0]  quo_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [DNW:0]   rem_o,
  output logic [DNW-1:0] den_o,
  output logic [QW-1:0]  quo_o,
  output logic [SW-1:0]  side_o
);

  logic           ge;
  logic [DNW:0]   diff;
  logic           valid_r;
  logic [DNW:0]   rem_r;
  logic [DNW-1:0] den_r;
  logic [QW-1:0]  quo_r;
  logic [SW-1:0]  side_r;

  assign ge   = (rem_i >= {1'b0, den_i});
  assign diff = ge ? (rem_i - {1'b0, den_i}) : rem_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= {diff[DNW-1:0], 1'b0};
      den_r  <= den_i;
      quo_r  <= {quo_i[QW-2:0], ge};
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign den_o   = den_r;
  assign quo_o   = quo_r;
  assign side_o  = side_r;

endmodule

@@ hw/rtl/segment_circle_intersection.sv @@
// ----------------------------------------------------------------------------
// segment_circle_intersection - lookahead point of a path segment
// Intersects segment S->E with the circle of radius r around the robot and
// returns the parameter t of the far crossing in [0,1], else the near one.
//
//   channel | dir | word content (low bits first)
//   --------+-----+----------------------------------------------------------
//   in_     | in  | seg_start_x, seg_start_y, seg_end_x, seg_end_y,
//           |     | robot_x, robot_y (COORD_WIDTH each, signed)
//   out_    | out | hit, t_param (T_FRAC_BITS+1), root_used, zero fill
//   cfg_    | in  | lookahead_radius (19 bits), write only
//
// One word enters per cycle and one leaves per cycle while out_tready is
// high. The pipeline runs through the front end, the square root chain
// (one root bit per cell), root selection, the divider chain (one
// quotient bit per cell) and the output register.
// Reset clears every stage valid and loads the radius default 4877.
// Each stage moves on when it is empty or its successor moves, so bubbles are
// squeezed out and words enter while a result waits and a stage is empty.
// ----------------------------------------------------------------------------
module segment_circle_intersection #(
  parameter int unsigned COORD_WIDTH = sci_pkg::COORD_WIDTH_DEF,
  parameter int unsigned T_FRAC_BITS = sci_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, robot_x, robot_y
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]    in_tdata,
  // hit, t_param, root_used
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((T_FRAC_BITS+3+7)/8)*8-1:0]    out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [sci_pkg::RADIUS_W-1:0]          cfg_wr_data
);

  localparam int unsigned IW   = ((6*COORD_WIDTH+7)/8)*8;
  localparam int unsigned OW   = ((T_FRAC_BITS+3+7)/8)*8;
  localparam int unsigned AW   = 2*COORD_WIDTH + 2;
  localparam int unsigned GW   = 2*COORD_WIDTH + 3;
  localparam int unsigned RB   = (AW + 2*sci_pkg::RADIUS_W + 2) / 2;
  localparam int unsigned SSW  = 1 + GW + AW;
  localparam int unsigned NW   = ((GW + 1 > RB) ? GW + 1 : RB) + 2;
  localparam int unsigned DNW  = AW + 1;
  localparam int unsigned QW   = T_FRAC_BITS + 1;
  localparam int unsigned NF   = sci_pkg::FRONT_STAGES;
  localparam int unsigned SEL  = NF + RB;
  localparam int unsigned OUTS = SEL + QW + 1;
  localparam int unsigned NST  = OUTS + 1;

  // radius register
  logic [sci_pkg::RADIUS_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= sci_pkg::RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  // stage valids and load enables, last stage first
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  assign en[NST-1] = !v[NST-1] || out_tready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign in_tready = en[0];

  // front end
  logic                  f_ok;
  logic [2*RB-1:0]       f_disc;
  logic signed [GW-1:0]  f_g;
  logic [AW-1:0]         f_a;

  sci_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en[NF-1:0]),
    .in_valid (in_tvalid),
    .in_data  (in_tdata[6*COORD_WIDTH-1:0]),
    .radius   (radius_r),
    .valid_o  (v[NF-1:0]),
    .ok_o     (f_ok),
    .disc_o   (f_disc),
    .g_o      (f_g),
    .a_o      (f_a)
  );

  // square root chain: one root bit per cell, payload rides along
  logic [RB:0]           sq_valid;
  logic [RB:0][RB+1:0]   sq_rem;
  logic [RB:0][RB-1:0]   sq_root;
  logic [RB:0][2*RB-1:0] sq_rad;
  logic [RB:0][SSW-1:0]  sq_side;

  assign sq_valid[0] = v[NF-1];
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_rad[0]   = f_disc;
  assign sq_side[0]  = {f_ok, f_g, f_a};

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    sci_sqrt_cell #(
      .RB (RB),
      .SW (SSW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en[NF+k]),
      .valid_i (sq_valid[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .rad_i   (sq_rad[k]),
      .side_i  (sq_side[k]),
      .valid_o (sq_valid[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1]),
      .rad_o   (sq_rad[k+1]),
      .side_o  (sq_side[k+1])
    );
    assign v[NF+k] = sq_valid[k+1];
  end

  // root selection: far root n2 = s - b, near root n1 = -b - s, den = 2a
  logic                 s_ok;
  logic signed [GW-1:0] s_g;
  logic [AW-1:0]        s_a;
  logic signed [NW-1:0] nb, sv, n2, n1, dv;
  logic                 in2, in1;
  logic                 sel_valid_r, sel_hit_nxt, sel_hit_r, sel_root1_r;
  logic [DNW-1:0]       sel_num_nxt, sel_num_r, sel_den_r;

  assign {s_ok, s_g, s_a} = sq_side[RB];
  assign nb  = -(NW'(s_g) <<< 1);
  assign sv  = $signed(NW'(sq_root[RB]));
  assign dv  = $signed(NW'({s_a, 1'b0}));
  assign n2  = nb + sv;
  assign n1  = nb - sv;
  assign in2 = !n2[NW-1] && (n2 <= dv);
  assign in1 = !n1[NW-1] && (n1 <= dv);

  assign sel_hit_nxt = s_ok && (in2 || in1);
  assign sel_num_nxt = in2 ? DNW'(unsigned'(n2)) : DNW'(unsigned'(n1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_valid_r <= 1'b0;
    end else if (en[SEL]) begin
      sel_valid_r <= sq_valid[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (en[SEL]) begin
      sel_hit_r   <= sel_hit_nxt;
      sel_root1_r <= !in2;
      sel_num_r   <= sel_num_nxt;
      sel_den_r   <= {s_a, 1'b0};
    end
  end

  assign v[SEL] = sel_valid_r;

  // divider chain: t = floor(num * 2^T_FRAC_BITS / den), MSB first
  logic [QW:0]          dv_valid;
  logic [QW:0][DNW:0]   dv_rem;
  logic [QW:0][DNW-1:0] dv_den;
  logic [QW:0][QW-1:0]  dv_quo;
  logic [QW:0][1:0]     dv_side;

  assign dv_valid[0] = sel_valid_r;
  assign dv_rem[0]   = {1'b0, sel_num_r};
  assign dv_den[0]   = sel_den_r;
  assign dv_quo[0]   = '0;
  assign dv_side[0]  = {sel_root1_r, sel_hit_r};

  for (genvar k = 0; k < QW; k++) begin : g_div
    sci_div_cell #(
      .DNW (DNW),
      .QW  (QW),
      .SW  (2)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en[SEL+1+k]),
      .valid_i (dv_valid[k]),
      .rem_i   (dv_rem[k]),
      .den_i   (dv_den[k]),
      .quo_i   (dv_quo[k]),
      .side_i  (dv_side[k]),
      .valid_o (dv_valid[k+1]),
      .rem_o   (dv_rem[k+1]),
      .den_o   (dv_den[k+1]),
      .quo_o   (dv_quo[k+1]),
      .side_o  (dv_side[k+1])
    );
    assign v[SEL+1+k] = dv_valid[k+1];
  end

  // output register: zero the fields of a miss
  logic          out_valid_r, out_hit_r, out_root_r;
  logic [QW-1:0] out_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en[OUTS]) begin
      out_valid_r <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUTS]) begin
      out_hit_r  <= dv_side[QW][0];
      out_t_r    <= dv_side[QW][0] ? dv_quo[QW] : '0;
      out_root_r <= dv_side[QW][0] && dv_side[QW][1];
    end
  end

  assign v[OUTS]     = out_valid_r;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = OW'({out_root_r, out_t_r, out_hit_r});

endmodule

@@ hw/rtl/sci_checker.sv @@
// ----------------------------------------------------------------------------
// sci_checker - port-level checks for segment_circle_intersection
// Watches the result channel and the input handshake over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sci_checker #(
  parameter int unsigned T_FRAC_BITS = sci_pkg::T_FRAC_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((T_FRAC_BITS+3+7)/8)*8-1:0]   out_tdata
);

  localparam int unsigned OW = ((T_FRAC_BITS+3+7)/8)*8;
  localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

  // no result word may leave the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // a miss carries zero t_param, root_used and fill
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[OW-1:1] == '0)
    else $error("miss word with nonzero fields");

  // a hit lies in [0,1]
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[T_FRAC_BITS+1:1] <= T_ONE)
    else $error("t_param above one");

  // an empty result side never blocks an offered input word
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !out_tvalid |-> in_tready)
    else $error("input blocked with empty result side");

endmodule

bind segment_circle_intersection sci_checker #(
  .T_FRAC_BITS (T_FRAC_BITS)
) u_sci_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb - segment / circle intersection testbench
// Drives segments and robot positions, predicts the lookahead crossing with
// exact wide integer math and checks every result word in order.
// ----------------------------------------------------------------------------
class crossing_board;
  typedef struct packed {
    logic        root_used;
    logic [16:0] t_param;
    logic        hit;
  } crossing_t;

  crossing_t   pending[$];
  logic [18:0] radius;
  int          errors;

  function new();
    radius = sci_pkg::RADIUS_RESET;
    errors = 0;
  endfunction

  // floor(n * 2^16 / den), low 17 bits
  function automatic logic [16:0] scale(logic signed [191:0] n,
                                        logic signed [191:0] den);
    logic signed [191:0] q;
    q = (n <<< 16) / den;
    return q[16:0];
  endfunction

  function automatic logic [191:0] isqrt(logic [191:0] v);
    logic [191:0] r;
    logic [191:0] cand;
    r = '0;
    for (int k = 95; k >= 0; k--) begin
      cand = r | (192'd1 << k);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  function void note_segment(logic [119:0] w);
    logic signed [191:0] sx, sy, ex, ey, px, py, dx, dy, fx, fy;
    logic signed [191:0] a, b, c, disc, s, den, n1, n2, rr;
    crossing_t e;
    sx = $signed(w[19:0]);   sy = $signed(w[39:20]);
    ex = $signed(w[59:40]);  ey = $signed(w[79:60]);
    px = $signed(w[99:80]);  py = $signed(w[119:100]);
    rr = {173'd0, radius};
    e = '0;
    dx = ex - sx; dy = ey - sy; fx = sx - px; fy = sy - py;
    a = dx * dx + dy * dy;
    if (a != 0) begin
      b = 2 * (fx * dx + fy * dy);
      c = fx * fx + fy * fy - rr * rr;
      disc = b * b - 4 * a * c;
      if (disc >= 0) begin
        s = isqrt(disc);
        den = 2 * a;
        n2 = -b + s;
        n1 = -b - s;
        if (n2 >= 0 && n2 <= den) begin
          e.hit = 1; e.t_param = scale(n2, den);
        end else if (n1 >= 0 && n1 <= den) begin
          e.hit = 1; e.t_param = scale(n1, den); e.root_used = 1;
        end
      end
    end
    pending.push_back(e);
  endfunction

  function void check_crossing(logic [23:0] w);
    crossing_t got, want;
    got = w[18:0];
    if (pending.size() == 0) begin
      $display("%0t: unexpected word, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.hit !== want.hit || got.t_param !== want.t_param
        || got.root_used !== want.root_used || w[23:19] !== 0) begin
      $display("%0t: mismatch expected hit=%0d t=%0d root=%0d actual hit=%0d t=%0d root=%0d",
               $time, want.hit, want.t_param, want.root_used,
               got.hit, got.t_param, got.root_used);
      errors++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 66;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;   // seg_start_x, seg_start_y, seg_end_x, seg_end_y, robot_x, robot_y
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [23:0]  out_tdata;       // hit, t_param, root_used, zero fill
  logic         cfg_wr_en = 0;
  logic [18:0]  cfg_wr_data = '0;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_off = 0;
  crossing_board board = new();

  always #2 clk = ~clk;

  segment_circle_intersection dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_wr_en, .cfg_wr_data
  );

  // Receiver: check at the rising edge, pick next ready at the falling edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_crossing(out_tdata);
  end

  always @(negedge clk) begin
    out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one word; valid stays high until it is taken, and stays high on
  // return so the next word can follow without a gap.
  task automatic send_segment(logic [119:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_segment(w);
    @(negedge clk);
  endtask

  // Drop valid after the last word of a burst.
  task automatic idle_input();
    in_tvalid <= 0;
    @(negedge clk);
  endtask

  task automatic send_points(int sx, int sy, int ex, int ey, int px, int py);
    send_segment({py[19:0], px[19:0], ey[19:0], ex[19:0], sy[19:0], sx[19:0]});
  endtask

  // Drain, then write the radius while the block is idle.
  task automatic set_radius(logic [18:0] r);
    idle_input();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_wr_en   <= 1;
    cfg_wr_data <= r;
    @(negedge clk);
    cfg_wr_en <= 0;
    board.radius = r;
  endtask

  function automatic int coord_pick();
    case ($urandom_range(3))
      0: return $urandom_range(1048575) - 524288;
      1: return $urandom_range(20000) - 10000;
      2: return $urandom_range(1) ? 524287 : -524288;
      default: return $urandom_range(200) - 100;
    endcase
  endfunction

  // Segment crossing the circle region around the robot most of the time.
  task automatic send_random();
    int px, py, sx, sy, ex, ey, span;
    if ($urandom_range(9) == 0) begin
      send_segment(120'({$urandom, $urandom, $urandom, $urandom}));
      return;
    end
    span = board.radius * 2 + 8;
    px = coord_pick() / 2; py = coord_pick() / 2;
    sx = px + $urandom_range(span) - span / 2;
    sy = py + $urandom_range(span) - span / 2;
    ex = px + $urandom_range(span) - span / 2;
    ey = py + $urandom_range(span) - span / 2;
    if ($urandom_range(19) == 0) begin ex = sx; ey = sy; end
    send_points(sx, sy, ex, ey, px, py);
  endtask

  task automatic run_phase(int n);
    for (int i = 0; i < n; i++) send_random();
    idle_input();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: reset radius, far/near crossings, misses, degenerate, extremes.
    send_points(-10000, 0, 10000, 0, 0, 0);           // both roots, larger
    send_points(0, 0, 10000, 0, 0, 0);                // start inside
    send_points(-10000, 0, 0, 0, 0, 0);               // only near crossing
    send_points(100, 100, 100, 100, 0, 0);            // zero length
    send_points(-10000, 9000, 10000, 9000, 0, 0);     // circle missed
    send_points(-100, 0, 100, 0, 0, 0);               // fully inside
    send_points(-10000, 4877, 10000, 4877, 0, 0);     // tangent
    send_points(4877, 0, 10000, 0, 0, 0);             // start on circle
    send_points(-524288, -524288, 524287, 524287, 524287, -524288);
    send_points(524287, 524287, -524288, -524288, -524288, -524288);
    send_points(-524288, 0, 524287, 0, 0, 0);
    send_segment({120{1'b1}});
    send_segment('0);
    set_radius(19'd0);
    send_points(-10, 0, 10, 0, 0, 0);                 // point circle on segment
    send_points(-10, 1, 10, 1, 0, 0);
    set_radius(19'h7FFFF);
    send_points(-524288, 0, 524287, 0, 0, 0);
    send_points(-524288, -524288, 524287, 524287, 0, 0);
    send_points(0, 0, 1, 1, 0, 0);

    // Long receiver hold-off while the sender keeps offering words.
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      run_phase(120);
    join

    set_radius(19'd3000);
    send_idle_pct = 19; recv_idle_pct = 73;
    run_phase(200);
    set_radius(sci_pkg::RADIUS_RESET);
    send_idle_pct = 73; recv_idle_pct = 19;
    run_phase(140);
    set_radius(19'd64);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_phase(140);

    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (board.errors == 0) $display("[segment_circle_intersection] OK");
    else $display("[segment_circle_intersection] ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("[segment_circle_intersection] ERROR");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/sci_pkg.sv
hw/rtl/sci_front.sv
hw/rtl/sci_sqrt_cell.sv
hw/rtl/sci_div_cell.sv
hw/rtl/segment_circle_intersection.sv
hw/rtl/sci_checker.sv
dv/tb.sv
